### sv/gam_pkg.sv
// Shared types and constants for the graph adjacency matrix block.
// Used by gam_ctrl, gam_dpath and graph_adjacency_matrix; depends on nothing.
package gam_pkg;

  // Field widths of the stream and config items
  localparam int CmdW      = 2;
  localparam int VertW     = 4;
  localparam int ValW      = 5;
  localparam int CountW    = 5;
  localparam int InDataW   = 16;  // cmd + vertex_a + vertex_b, padded to bytes
  localparam int OutDataW  = 8;   // result_value, padded to a byte
  localparam int OutUserW  = 2;   // bad_vertex, empty_list

  localparam logic [CountW-1:0] VertexCountReset = 5'd16;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_ADD       = 2'd1,
    CMD_DEGREE    = 2'd2,
    CMD_NEIGHBORS = 2'd3
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic clear_all;
    logic add_edge;
    logic load_row;
    logic emit_bad;
    logic emit_degree;
    logic emit_neighbor;
    logic emit_empty;
  } gam_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e cmd;
    logic a_ok;
    logic ab_ok;
    logic row_zero;
    logic last_nb;
    logic out_free;
  } gam_stat_t;

endpackage

### sv/gam_ctrl.sv
// Controller state machine for the graph adjacency matrix block.
// Depends on gam_pkg for the command and status structs.
module gam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gam_pkg::gam_stat_t  stat_i,
  output gam_pkg::gam_cmd_t   ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEGREE,
    ST_SCAN
  } st_e;

  st_e  state_q, state_d;
  logic ready_q;

  // Next state and datapath commands
  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          ctl_o.take_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat_i.cmd)
          gam_pkg::CMD_CLEAR: begin
            ctl_o.clear_all = 1'b1;
            state_d         = ST_IDLE;
          end
          gam_pkg::CMD_ADD: begin
            if (stat_i.ab_ok) begin
              ctl_o.add_edge = 1'b1;
              state_d        = ST_IDLE;
            end else if (stat_i.out_free) begin
              ctl_o.emit_bad = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          default: begin
            // degree or neighbor query
            if (!stat_i.a_ok) begin
              if (stat_i.out_free) begin
                ctl_o.emit_bad = 1'b1;
                state_d        = ST_IDLE;
              end
            end else begin
              ctl_o.load_row = 1'b1;
              state_d = (stat_i.cmd == gam_pkg::CMD_DEGREE) ? ST_DEGREE : ST_SCAN;
            end
          end
        endcase
      end
      ST_DEGREE: begin
        if (stat_i.out_free) begin
          ctl_o.emit_degree = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat_i.out_free) begin
          if (stat_i.row_zero) begin
            ctl_o.emit_empty = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            ctl_o.emit_neighbor = 1'b1;
            if (stat_i.last_nb) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

### sv/gam_dpath.sv
// Datapath of the graph adjacency matrix block: bit matrix, vertex count,
// row scan, degree count and output register. Depends on gam_pkg.
module gam_dpath #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gam_pkg::gam_cmd_t                 ctl_i,
  output gam_pkg::gam_stat_t                stat_o,
  input  logic [gam_pkg::InDataW-1:0]       in_data_i,
  input  logic                              cfg_valid_i,
  input  logic [gam_pkg::CountW-1:0]        cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [gam_pkg::OutDataW-1:0]      out_data_o,
  output logic                              out_last_o,
  output logic [gam_pkg::OutUserW-1:0]      out_user_o
);

  // Only vertices reachable by a 4-bit index ever hold edges
  localparam int VMax = 1 << gam_pkg::VertW;
  localparam int NumV = (MAX_VERTICES < VMax) ? MAX_VERTICES : VMax;
  localparam int IdxW = $clog2(NumV);
  localparam int CW   = gam_pkg::CountW;
  localparam int VW   = gam_pkg::VertW;

  logic [NumV-1:0]     adj_q [NumV];
  logic [CW-1:0]       vcnt_q;
  gam_pkg::cmd_e       cmd_q;
  logic [VW-1:0]       a_q, b_q;
  logic [NumV-1:0]     row_q;

  logic                out_valid_q, out_last_q, out_bad_q, out_empty_q;
  logic [gam_pkg::ValW-1:0] out_value_q;

  logic [CW-1:0]       active_n;
  logic                a_ok, b_ok, out_free;
  logic [NumV-1:0]     col_mask, row_sel, row_rest;
  logic [CW-1:0]       degree;
  logic [IdxW-1:0]     low_idx;
  logic                emit_any;

  // Active count, capped at the stored size
  assign active_n = (vcnt_q > CW'(NumV)) ? CW'(NumV) : vcnt_q;
  assign a_ok     = {1'b0, a_q} < active_n;
  assign b_ok     = {1'b0, b_q} < active_n;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    for (int j = 0; j < NumV; j++) begin
      col_mask[j] = CW'(j) < active_n;
    end
  end

  assign row_sel  = adj_q[a_q[IdxW-1:0]] & col_mask;
  assign row_rest = row_q & (row_q - NumV'(1));

  // Degree: set bits of the latched row
  always_comb begin
    degree = '0;
    for (int j = 0; j < NumV; j++) begin
      degree = degree + CW'(row_q[j]);
    end
  end

  // Lowest set column of the latched row
  always_comb begin
    low_idx = '0;
    for (int j = NumV - 1; j >= 0; j--) begin
      if (row_q[j]) begin
        low_idx = IdxW'(j);
      end
    end
  end

  // Vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= gam_pkg::VertexCountReset;
    end else if (cfg_valid_i) begin
      vcnt_q <= cfg_data_i;
    end
  end

  // Adjacency matrix: cleared at reset and by the clear command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumV; i++) begin
        adj_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumV; i++) begin
        for (int j = 0; j < NumV; j++) begin
          if (ctl_i.clear_all) begin
            adj_q[i][j] <= 1'b0;
          end else if (ctl_i.add_edge &&
                       ((a_q == VW'(i) && b_q == VW'(j)) ||
                        (a_q == VW'(j) && b_q == VW'(i)))) begin
            adj_q[i][j] <= 1'b1;
          end
        end
      end
    end
  end

  // Item capture and row scan register
  always_ff @(posedge clk_i) begin
    if (ctl_i.take_item) begin
      cmd_q <= gam_pkg::cmd_e'(in_data_i[gam_pkg::CmdW-1:0]);
      a_q   <= in_data_i[gam_pkg::CmdW +: VW];
      b_q   <= in_data_i[gam_pkg::CmdW + VW +: VW];
    end
    if (ctl_i.load_row) begin
      row_q <= row_sel;
    end else if (ctl_i.emit_neighbor) begin
      row_q <= row_rest;
    end
  end

  assign emit_any = ctl_i.emit_bad | ctl_i.emit_degree | ctl_i.emit_neighbor |
                    ctl_i.emit_empty;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      out_bad_q   <= ctl_i.emit_bad;
      out_empty_q <= ctl_i.emit_empty;
      out_last_q  <= ctl_i.emit_bad | ctl_i.emit_degree | ctl_i.emit_empty |
                     (row_rest == '0);
      if (ctl_i.emit_degree) begin
        out_value_q <= degree;
      end else if (ctl_i.emit_neighbor) begin
        out_value_q <= gam_pkg::ValW'(low_idx);
      end else begin
        out_value_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = gam_pkg::OutDataW'(out_value_q);
  assign out_last_o  = out_last_q;
  assign out_user_o  = {out_empty_q, out_bad_q};

  assign stat_o.cmd      = cmd_q;
  assign stat_o.a_ok     = a_ok;
  assign stat_o.ab_ok    = a_ok & b_ok;
  assign stat_o.row_zero = (row_q == '0);
  assign stat_o.last_nb  = (row_rest == '0);
  assign stat_o.out_free = out_free;

  // Checks
  a_one_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.emit_bad, ctl_i.emit_degree, ctl_i.emit_neighbor, ctl_i.emit_empty}))
    else $error("more than one result source in a cycle");

  a_emit_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_any |-> out_free)
    else $error("result written over a waiting item");

  a_scan_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit_neighbor |-> (row_q != '0))
    else $error("neighbor emitted from an empty row");

  a_flag_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_bad_q || out_empty_q)) |-> (out_last_q && out_value_q == '0))
    else $error("error or empty result not final or not zero");

endmodule

### sv/graph_adjacency_matrix.sv
// Graph adjacency matrix, top level: stream ports and config write port.
// Depends on gam_pkg, gam_ctrl and gam_dpath.
//
// Holds a symmetric bit matrix of an undirected graph and answers one command
// per input item: clear, add edge, degree query, neighbor list. The block takes
// one item at a time. A neighbor query gives at least one result: the row
// scan emits one neighbor per cycle while the output is free, lowest index
// first. Results leave through an output register, so the next item is taken
// while the final result of the last one still waits; a stalled result holds
// the scan. The matrix is cleared at reset, and a change of vertex_count keeps
// stored edges but hides rows and columns at or above the count. Only write the
// config register while no item is in flight.
module graph_adjacency_matrix #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: cmd [1:0], vertex_a [5:2], vertex_b [9:6], zeros above
  input  logic [gam_pkg::InDataW-1:0]        s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: result_value [4:0], zeros above
  output logic [gam_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser: bad_vertex [0], empty_list [1]
  output logic [gam_pkg::OutUserW-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // vertex_count write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gam_pkg::CountW-1:0]         cfg_data_i
);

  gam_pkg::gam_cmd_t  ctl;
  gam_pkg::gam_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  gam_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule
